>>> sv/ssta_pkg.sv
// ----------------------------------------------------------------------------
// ssta_pkg
// Shared types and codes of the sprite slot table animator.
// ----------------------------------------------------------------------------
package ssta_pkg;

  // command codes
  localparam logic [3:0] CMD_RESET = 4'd0;
  localparam logic [3:0] CMD_ADD   = 4'd1;
  localparam logic [3:0] CMD_CHG   = 4'd2;
  localparam logic [3:0] CMD_DEL   = 4'd3;
  localparam logic [3:0] CMD_POS   = 4'd4;
  localparam logic [3:0] CMD_HIDE  = 4'd5;
  localparam logic [3:0] CMD_SHOW  = 4'd6;
  localparam logic [3:0] CMD_DRAW  = 4'd7;
  localparam logic [3:0] CMD_ERASE = 4'd8;

  // result kinds
  localparam logic [2:0] KIND_ACK    = 3'd0;
  localparam logic [2:0] KIND_SLOT   = 3'd1;
  localparam logic [2:0] KIND_FULL   = 3'd2;
  localparam logic [2:0] KIND_DRAW   = 3'd3;
  localparam logic [2:0] KIND_ERASE  = 3'd4;
  localparam logic [2:0] KIND_NONE   = 3'd5;

  localparam logic [15:0] HIDE_MAX = 16'hFFFF;

  // one slot entry in the table memory
  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [9:0]  w;
    logic [9:0]  h;
    logic [7:0]  frames;
    logic [7:0]  frame;
    logic        att;
    logic        wave;
    logic        back;
    logic [2:0]  mode;
  } entry_t;

endpackage

>>> sv/sprite_slot_table_animator.sv
// ----------------------------------------------------------------------------
// sprite_slot_table_animator
// Sprite slot table with draw/erase listing and frame animation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in_*    | input     | in_valid / in_stall
//  out_*   | output    | out_valid / out_stall
//
// Reset, add, delete, hide, show, unknown codes and hidden or empty ticks:
// one result, loaded from the ST_OUT state after acceptance.
// Change and set position: read (ST_READ), write back (ST_EMIT), result (ST_OUT).
// Draw and erase walk the live slots one per cycle through the one read port
// of the slot memory, unless an output stall holds the walk; the first record
// is loaded after ST_EMIT picks the first live slot and ST_WALK reads it.
// The reset pin clears live flags and hide count at once; no clearing pass.
// A stalled result holds the walk; no new transaction is taken until the
// last result has left.
module sprite_slot_table_animator #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_command,
  input  logic [5:0]        in_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [9:0]        in_sprite_width,
  input  logic [9:0]        in_sprite_height,
  input  logic [7:0]        in_frame_count,
  input  logic              in_attached,
  input  logic              in_wave_anim,
  input  logic [2:0]        in_draw_mode,
  input  logic signed [15:0] in_mouse_x,
  input  logic signed [15:0] in_mouse_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic [5:0]        out_slot,
  output logic signed [15:0] out_screen_x,
  output logic signed [15:0] out_screen_y,
  output logic [9:0]        out_width,
  output logic [9:0]        out_height,
  output logic [7:0]        out_frame,
  output logic [2:0]        out_mode,
  output logic              out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_WALK = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // slot memory, one read and one write port
  ssta_pkg::entry_t mem [SLOTS];
  ssta_pkg::entry_t rd_q;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  ssta_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  logic [SLOTS-1:0] live_r;
  logic [15:0]      hide_r;

  // latched command
  logic [3:0]  cmd_r;
  logic [IW-1:0] sl_r;
  logic        sl_ok_r;
  logic [15:0] px_r, py_r, mx_r, my_r;
  logic [9:0]  w_r, h_r;
  logic [7:0]  fc_r;
  logic        att_r, wave_r;
  logic [2:0]  mode_r;

  // walk
  logic [IW-1:0] idx_r;      // slot under read
  logic [IW-1:0] eidx_r;     // slot whose data is in rd_q
  logic          ev_r;       // rd_q valid for a live slot
  logic          wdone_r;    // read index has passed the end

  // output register
  logic        ov_r;
  logic [2:0]  kind_r;
  logic [5:0]  oslot_r;
  logic [15:0] ox_r, oy_r;
  logic [9:0]  ow_r, oh_r;
  logic [7:0]  ofr_r;
  logic [2:0]  omode_r;
  logic        olast_r;

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (ov_r && out_stall);

  logic accept;
  assign accept = in_valid && !in_stall;

  // output register loads a result this cycle
  logic ov_set;
  assign ov_set = out_free && ((state_r == ST_WALK && ev_r) || state_r == ST_OUT);

  // lowest free slot search, combinational over live flags
  logic [IW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  // next live slot strictly after idx, in walk direction
  logic          is_erase;
  assign is_erase = (cmd_r == ssta_pkg::CMD_ERASE);
  logic          nxt_ok;
  logic [IW-1:0] nxt_idx;
  always_comb begin
    nxt_ok  = 1'b0;
    nxt_idx = '0;
    if (is_erase) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (live_r[i] && IW'(i) < idx_r) begin
          nxt_ok = 1'b1;
          nxt_idx = IW'(i);
        end
      end
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (live_r[i] && IW'(i) > idx_r) begin
          nxt_ok = 1'b1;
          nxt_idx = IW'(i);
        end
      end
    end
  end

  // animation step of the entry in rd_q
  ssta_pkg::entry_t stepped;
  always_comb begin
    stepped = rd_q;
    if (rd_q.frames > 8'd1) begin
      if (rd_q.wave && rd_q.frames > 8'd2) begin
        if (rd_q.back) begin
          if (rd_q.frame == 8'd0) begin
            stepped.frame = 8'd1;
            stepped.back  = 1'b0;
          end else begin
            stepped.frame = rd_q.frame - 8'd1;
          end
        end else if (rd_q.frame == rd_q.frames - 8'd1) begin
          stepped.frame = rd_q.frames - 8'd2;
          stepped.back  = 1'b1;
        end else begin
          stepped.frame = rd_q.frame + 8'd1;
        end
      end else begin
        stepped.frame = (rd_q.frame == rd_q.frames - 8'd1) ? 8'd0 : rd_q.frame + 8'd1;
      end
    end
  end

  // record position
  logic [15:0] rx, ry;
  assign rx = rd_q.att ? rd_q.px + mx_r : rd_q.px;
  assign ry = rd_q.att ? rd_q.py + my_r : rd_q.py;

  logic [IW-1:0] first_idx;
  logic          first_ok;
  always_comb begin
    first_ok  = |live_r;
    first_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!is_erase && live_r[i]) first_idx = IW'(i);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (is_erase && live_r[i]) first_idx = IW'(i);
    end
  end

  logic [IW-1:0] sl_idx_in;
  assign sl_idx_in = in_slot[IW-1:0];

  // control and datapath
  always_comb begin
    state_nxt = state_r;
    rd_addr   = sl_r;
    wr_en     = 1'b0;
    wr_addr   = sl_r;
    wr_data   = rd_q;
    case (state_r)
      ST_IDLE: ;
      ST_READ: rd_addr = sl_r;
      // a held record keeps its own entry in rd_q
      ST_WALK: rd_addr = (ev_r && !out_free) ? eidx_r : idx_r;
      ST_EMIT: rd_addr = idx_r;
      ST_OUT: ;
      default: ;
    endcase
    // change writes back on the cycle after its read
    if (state_r == ST_EMIT && cmd_r == ssta_pkg::CMD_CHG) begin
      wr_en = sl_ok_r && live_r[sl_r];
      wr_data.px = px_r;
      wr_data.py = py_r;
      wr_data.w  = w_r;
      wr_data.h  = h_r;
      wr_data.frames = fc_r;
      wr_data.att  = att_r;
      wr_data.wave = wave_r;
      wr_data.back = 1'b0;
      wr_data.mode = mode_r;
      wr_data.frame = (rd_q.frame >= fc_r) ? 8'd0 : rd_q.frame;
    end
    if (state_r == ST_EMIT && cmd_r == ssta_pkg::CMD_POS) begin
      wr_en = sl_ok_r;
      wr_data.px = px_r;
      wr_data.py = py_r;
    end
    // draw writes back the stepped frame when its record is taken
    if (state_r == ST_WALK && ev_r && out_free && cmd_r == ssta_pkg::CMD_DRAW) begin
      wr_en   = 1'b1;
      wr_addr = eidx_r;
      wr_data = stepped;
    end
    if (state_r == ST_IDLE && accept && in_command == ssta_pkg::CMD_ADD && free_any) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data.px = in_pos_x;
      wr_data.py = in_pos_y;
      wr_data.w  = in_sprite_width;
      wr_data.h  = in_sprite_height;
      wr_data.frames = in_frame_count;
      wr_data.frame  = 8'd0;
      wr_data.att  = in_attached;
      wr_data.wave = in_wave_anim;
      wr_data.back = 1'b0;
      wr_data.mode = in_draw_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      live_r  <= '0;
      hide_r  <= '0;
      ov_r    <= 1'b0;
      ev_r    <= 1'b0;
      wdone_r <= 1'b0;
    end else begin
      ov_r <= ov_set || (ov_r && out_stall);
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r  <= in_command;
            sl_r   <= sl_idx_in;
            sl_ok_r <= (32'(in_slot) < SLOTS);
            px_r <= in_pos_x;  py_r <= in_pos_y;
            mx_r <= in_mouse_x; my_r <= in_mouse_y;
            w_r <= in_sprite_width; h_r <= in_sprite_height;
            fc_r <= in_frame_count; att_r <= in_attached; wave_r <= in_wave_anim;
            mode_r <= in_draw_mode;
            kind_r <= ssta_pkg::KIND_ACK;
            oslot_r <= '0;
            state_r <= ST_OUT;
            case (in_command)
              ssta_pkg::CMD_RESET: begin
                live_r <= '0;
                hide_r <= '0;
              end
              ssta_pkg::CMD_ADD: begin
                if (free_any) begin
                  live_r[free_idx] <= 1'b1;
                  kind_r  <= ssta_pkg::KIND_SLOT;
                  oslot_r <= 6'(free_idx);
                end else begin
                  kind_r <= ssta_pkg::KIND_FULL;
                end
              end
              ssta_pkg::CMD_CHG, ssta_pkg::CMD_POS: state_r <= ST_READ;
              ssta_pkg::CMD_DEL: begin
                if (32'(in_slot) < SLOTS) live_r[sl_idx_in] <= 1'b0;
              end
              ssta_pkg::CMD_HIDE: if (hide_r != ssta_pkg::HIDE_MAX) hide_r <= hide_r + 16'd1;
              ssta_pkg::CMD_SHOW: if (hide_r != 16'd0) hide_r <= hide_r - 16'd1;
              ssta_pkg::CMD_DRAW, ssta_pkg::CMD_ERASE: begin
                kind_r <= ssta_pkg::KIND_NONE;
                if (hide_r == 16'd0 && (|live_r)) state_r <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_READ: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (cmd_r == ssta_pkg::CMD_DRAW || cmd_r == ssta_pkg::CMD_ERASE) begin
            // start the walk: first live slot is read on the next cycle
            idx_r   <= first_idx;
            ev_r    <= 1'b0;
            wdone_r <= !first_ok;
            state_r <= ST_WALK;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_WALK: begin
          if (!ev_r || out_free) begin
            if (ev_r) begin
              kind_r  <= is_erase ? ssta_pkg::KIND_ERASE : ssta_pkg::KIND_DRAW;
              oslot_r <= 6'(eidx_r);
              ox_r <= rx; oy_r <= ry;
              ow_r <= rd_q.w; oh_r <= rd_q.h;
              ofr_r <= rd_q.frame; omode_r <= rd_q.mode;
              olast_r <= wdone_r;
            end
            if (wdone_r) begin
              ev_r    <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              ev_r   <= 1'b1;
              eidx_r <= idx_r;
              idx_r  <= nxt_idx;
              wdone_r <= !nxt_ok;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            ox_r <= '0; oy_r <= '0; ow_r <= '0; oh_r <= '0;
            ofr_r <= '0; omode_r <= '0;
            olast_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = ov_r;
  assign out_kind     = kind_r;
  assign out_slot     = oslot_r;
  assign out_screen_x = ox_r;
  assign out_screen_y = oy_r;
  assign out_width    = ow_r;
  assign out_height   = oh_r;
  assign out_frame    = ofr_r;
  assign out_mode     = omode_r;
  assign out_last     = olast_r;

  // a new transaction is never taken while a result is unfinished
  a_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == ST_IDLE) else $error("accept outside idle");
  // hide count saturates
  a_hide: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == ssta_pkg::CMD_HIDE && hide_r == ssta_pkg::HIDE_MAX
    |=> hide_r == ssta_pkg::HIDE_MAX) else $error("hide count wrapped");
  // a result held under stall keeps its last flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(olast_r)) else $error("result lost");

endmodule
